FILE: rtl/ssva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssva_pkg;

  localparam int KEY_W  = 31;
  localparam int COEF_W = 64;
  localparam int ENT_W  = KEY_W + COEF_W;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ACC   = 2'd0;
  localparam kind_t KIND_OVW   = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;
  localparam kind_t KIND_READ  = 2'd3;

  typedef logic [2:0] status_t;
  localparam status_t ST_UPDATED  = 3'd0;
  localparam status_t ST_INSERTED = 3'd1;
  localparam status_t ST_DROPPED  = 3'd2;
  localparam status_t ST_FULL     = 3'd3;
  localparam status_t ST_READ_OK  = 3'd4;
  localparam status_t ST_READ_BAD = 3'd5;

  localparam logic [2:0] REG_STORE_ZEROS = 3'd0;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              cmp;
    logic              ins;
    logic              upd;
    logic              rd;
    logic [KEY_W-1:0]  key;
    logic [COEF_W-1:0] coef;
  } cell_ctl_t;

  function automatic logic [COEF_W-1:0] sat_add(input logic [COEF_W-1:0] a,
                                                input logic [COEF_W-1:0] b);
    logic [COEF_W-1:0] s;
    begin
      s = a + b;
      if ((a[COEF_W-1] == b[COEF_W-1]) && (s[COEF_W-1] != a[COEF_W-1])) begin
        sat_add = a[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
      end else begin
        sat_add = s;
      end
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssva_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ssva_cell
  import ssva_pkg::*;
#(
  parameter int POS = 0,
  parameter int CW  = 9
) (
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [CW-1:0]     count,
  input  wire logic              left_lt,
  input  wire logic [KEY_W-1:0]  left_idx,
  input  wire logic [COEF_W-1:0] left_coef,
  output logic                   lt,
  output logic                   sel,
  output logic [KEY_W-1:0]       idx,
  output logic [COEF_W-1:0]      coef
);

  logic occupied;

  assign occupied = CW'(POS) < count;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt  <= occupied && (idx < ctl.key);
      sel <= ctl.rd ? (occupied && (ctl.key == KEY_W'(POS)))
                    : (occupied && (idx == ctl.key));
    end
    if (ctl.ins && !lt) begin
      // first cell not below the key takes the new entry, the rest shift up
      idx  <= left_lt ? ctl.key  : left_idx;
      coef <= left_lt ? ctl.coef : left_coef;
    end else if (ctl.upd && sel) begin
      coef <= ctl.coef;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssva_gather.sv
`timescale 1ns / 1ps
`default_nettype none

module ssva_gather
  import ssva_pkg::*;
#(
  parameter int N = 256
) (
  input  wire logic                       clk,
  input  wire logic [N-1:0]               sel,
  input  wire logic [N-1:0][ENT_W-1:0]    ent,
  output logic                            hit,
  output logic [ENT_W-1:0]                hit_ent
);

  localparam int G  = 16;
  localparam int NG = (N + G - 1) / G;

  logic [NG-1:0]             grp_hit;
  logic [NG-1:0][ENT_W-1:0]  grp_ent;
  logic [NG-1:0]             grp_hit_next;
  logic [NG-1:0][ENT_W-1:0]  grp_ent_next;
  logic                      hit_next;
  logic [ENT_W-1:0]          hit_ent_next;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_next[g] = 1'b0;
      grp_ent_next[g] = '0;
      for (int j = 0; j < G; j++) begin
        if (g * G + j < N) begin
          grp_hit_next[g] = grp_hit_next[g] | sel[g*G+j];
          grp_ent_next[g] = grp_ent_next[g] | (ent[g*G+j] & {ENT_W{sel[g*G+j]}});
        end
      end
    end
  end

  always_comb begin
    hit_next     = 1'b0;
    hit_ent_next = '0;
    for (int g = 0; g < NG; g++) begin
      hit_next     = hit_next | grp_hit[g];
      hit_ent_next = hit_ent_next | grp_ent[g];
    end
  end

  always_ff @(posedge clk) begin
    grp_hit <= grp_hit_next;
    grp_ent <= grp_ent_next;
    hit     <= hit_next;
    hit_ent <= hit_ent_next;
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_sparse_vector_accumulator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  signals                  beat
// s_axis    in   tdata/tuser/tlast        eqn_index, coefficient, kind, batch_end
// m_axis    out  tdata/tlast              status, entry_count, out_index,
//                                         out_coefficient, batch_done
// apb       in   psel/penable/pwrite/...  store_zeros at address 0
//
// An item passes through accept, compare in all cells, the registered gather
// tree (group level, then total), then commit (insert shift or update) into the chain.
// Commit waits while the previous result sits unaccepted on m_axis.
// Synchronous reset empties the vector and sets store_zeros; no clearing pass.

module sorted_sparse_vector_accumulator_unit
  import ssva_pkg::*;
#(
  parameter int   CAPACITY = 256,
  localparam int  CW       = $clog2(CAPACITY + 1),
  localparam int  OUT_W    = ((3 + CW + KEY_W + COEF_W + 7) / 8) * 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [95:0]       s_axis_tdata,  // eqn_index[30:0], coefficient[94:31]
  input  wire logic [1:0]        s_axis_tuser,  // kind
  input  wire logic              s_axis_tlast,  // batch_end
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,  // status, entry_count, out_index,
                                                // out_coefficient
  output logic                   m_axis_tlast,  // batch_done
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_G1   = 5'b00100,
    S_G2   = 5'b01000,
    S_EXEC = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic                store_zeros;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  kind_t               it_kind;
  logic [KEY_W-1:0]    it_key;
  logic [COEF_W-1:0]   it_coef;
  logic                it_last;

  cell_ctl_t                        ctl;
  logic [CAPACITY-1:0]              c_lt;
  logic [CAPACITY-1:0]              c_sel;
  logic [CAPACITY-1:0][KEY_W-1:0]   c_idx;
  logic [CAPACITY-1:0][COEF_W-1:0]  c_coef;
  logic [CAPACITY-1:0][ENT_W-1:0]   c_ent;
  logic                             g_hit;
  logic [ENT_W-1:0]                 g_ent;
  logic [KEY_W-1:0]                 g_idx;
  logic [COEF_W-1:0]                g_coef;

  logic                commit;
  logic                do_ins;
  logic                do_upd;
  logic [COEF_W-1:0]   new_coef;
  status_t             res_status;
  logic [KEY_W-1:0]    res_idx;
  logic [COEF_W-1:0]   res_coef;
  status_t             o_status;
  logic [CW-1:0]       o_count;
  logic [KEY_W-1:0]    o_idx;
  logic [COEF_W-1:0]   o_coef;

  // config port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == REG_STORE_ZEROS) begin
      prdata = {31'd0, store_zeros};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_zeros <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == REG_STORE_ZEROS) begin
      store_zeros <= pwdata[0];
    end
  end

  // cell chain
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        ssva_cell #(.POS(i), .CW(CW)) u_cell (
          .clk(clk), .ctl(ctl), .count(count),
          .left_lt(1'b1), .left_idx('0), .left_coef('0),
          .lt(c_lt[i]), .sel(c_sel[i]), .idx(c_idx[i]), .coef(c_coef[i])
        );
      end else begin : g_body
        ssva_cell #(.POS(i), .CW(CW)) u_cell (
          .clk(clk), .ctl(ctl), .count(count),
          .left_lt(c_lt[i-1]), .left_idx(c_idx[i-1]), .left_coef(c_coef[i-1]),
          .lt(c_lt[i]), .sel(c_sel[i]), .idx(c_idx[i]), .coef(c_coef[i])
        );
      end
      assign c_ent[i] = {c_idx[i], c_coef[i]};
    end
  endgenerate

  ssva_gather #(.N(CAPACITY)) u_gather (
    .clk(clk), .sel(c_sel), .ent(c_ent), .hit(g_hit), .hit_ent(g_ent)
  );

  assign g_idx  = g_ent[ENT_W-1:COEF_W];
  assign g_coef = g_ent[COEF_W-1:0];

  // commit decision
  assign commit   = (state == S_EXEC) && (!m_axis_tvalid || m_axis_tready);
  assign new_coef = (it_kind == KIND_ACC) ? sat_add(g_coef, it_coef) : it_coef;

  always_comb begin
    do_ins     = 1'b0;
    do_upd     = 1'b0;
    res_status = ST_UPDATED;
    res_idx    = '0;
    res_coef   = '0;
    count_next = count;
    case (it_kind)
      KIND_CLEAR: begin
        count_next = '0;
      end
      KIND_READ: begin
        if (g_hit) begin
          res_status = ST_READ_OK;
          res_idx    = g_idx;
          res_coef   = g_coef;
        end else begin
          res_status = ST_READ_BAD;
        end
      end
      default: begin
        res_idx = it_key;
        if (it_kind == KIND_ACC && !store_zeros && it_coef == '0) begin
          res_status = ST_DROPPED;
          res_coef   = g_hit ? g_coef : '0;
        end else if (g_hit) begin
          do_upd     = 1'b1;
          res_status = ST_UPDATED;
          res_coef   = new_coef;
        end else if (count == CW'(CAPACITY)) begin
          res_status = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          res_status = ST_INSERTED;
          res_coef   = it_coef;
          count_next = count + 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    ctl.cmp  = (state == S_LOOK);
    ctl.ins  = commit && do_ins;
    ctl.upd  = commit && do_upd;
    ctl.rd   = (it_kind == KIND_READ);
    ctl.key  = it_key;
    ctl.coef = do_upd ? new_coef : it_coef;
  end

  // sequencer
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_LOOK;
      S_LOOK: state_next = S_G1;
      S_G1:   state_next = S_G2;
      S_G2:   state_next = S_EXEC;
      S_EXEC: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count         <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      it_kind <= s_axis_tuser;
      it_key  <= s_axis_tdata[KEY_W-1:0];
      it_coef <= s_axis_tdata[KEY_W+COEF_W-1:KEY_W];
      it_last <= s_axis_tlast;
    end
    if (commit) begin
      o_status     <= res_status;
      o_count      <= count_next;
      o_idx        <= res_idx;
      o_coef       <= res_coef;
      m_axis_tlast <= it_last;
    end
  end

  assign m_axis_tdata = {{(OUT_W - 3 - CW - KEY_W - COEF_W){1'b0}},
                         o_coef, o_idx, o_count, o_status};

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (commit && it_kind == KIND_CLEAR) |=> (count == '0))
    else $error("clear left entries");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && do_ins) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow count");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(c_sel))
    else $error("more than one cell selected");

endmodule

`default_nettype wire

FILE: bench/sorted_sparse_vector_accumulator_unit_tb.sv
`timescale 1ns / 1ps

module sorted_sparse_vector_accumulator_unit_tb;
  import ssva_pkg::*;

  localparam int DEPTH     = 256;
  localparam int CNT_W     = 9;
  localparam int OUT_W     = ((3 + CNT_W + KEY_W + COEF_W + 7) / 8) * 8;
  localparam int IDLE_MAX  = 4000;
  localparam int HOLD_LEN  = 300;
  localparam int MAX_SHOWN = 10;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [KEY_W-1:0]  KEY_TOP  = {KEY_W{1'b1}};

  typedef struct packed {
    kind_t             kind;
    logic [KEY_W-1:0]  idx;
    logic [COEF_W-1:0] coef;
    logic              last;
  } vec_op_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  count;
    logic [KEY_W-1:0]  idx;
    logic [COEF_W-1:0] coef;
    logic              done;
  } vec_resp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata = '0;   // eqn_index[30:0], coefficient[94:31]
  logic [1:0]        s_axis_tuser = '0;   // kind
  logic              s_axis_tlast = 1'b0; // batch_end
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;        // status, entry_count, out_index, out_coefficient
  logic              m_axis_tlast;        // batch_done
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  sorted_sparse_vector_accumulator_unit #(.CAPACITY(DEPTH)) i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mirror of the vector
  logic [KEY_W-1:0]  entry_keys [DEPTH];
  logic [COEF_W-1:0] entry_coefs [DEPTH];
  int unsigned       entry_total = 0;
  logic              keep_zeros = 1'b1;

  vec_op_t   pending_ops[$];
  vec_resp_t expected_results[$];
  vec_op_t   op_on_bus;
  bit        op_taken = 0;

  int s_idle_pct = 0;
  int r_idle_pct = 0;
  bit long_hold_req = 0;
  bit long_hold_done = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int ops_sent = 0;
  int resp_seen = 0;
  int status_seen [6] = '{default: 0};
  int kind_seen [4] = '{default: 0};

  function automatic logic [COEF_W-1:0] clamp_sum(input logic [COEF_W-1:0] a,
                                                  input logic [COEF_W-1:0] b);
    logic [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) return s[COEF_W] ? COEF_MIN : COEF_MAX;
    return s[COEF_W-1:0];
  endfunction

  task automatic update_vector_and_predict(input vec_op_t op);
    vec_resp_t   r;
    int unsigned p;
    int unsigned q;
    bit          hit;
    r = '0;
    r.done = op.last;
    r.status = ST_UPDATED;
    if (op.kind == KIND_CLEAR) begin
      entry_total = 0;
    end else if (op.kind == KIND_READ) begin
      if (op.idx < entry_total) begin
        r.status = ST_READ_OK;
        r.idx = entry_keys[op.idx];
        r.coef = entry_coefs[op.idx];
      end else begin
        r.status = ST_READ_BAD;
      end
    end else begin
      p = 0;
      while (p < entry_total && entry_keys[p] < op.idx) p++;
      hit = (p < entry_total) && (entry_keys[p] == op.idx);
      r.idx = op.idx;
      if (op.kind == KIND_ACC && !keep_zeros && op.coef == '0) begin
        r.status = ST_DROPPED;
        r.coef = hit ? entry_coefs[p] : '0;
      end else if (hit) begin
        entry_coefs[p] = (op.kind == KIND_ACC) ? clamp_sum(entry_coefs[p], op.coef) : op.coef;
        r.coef = entry_coefs[p];
      end else if (entry_total >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        for (q = entry_total; q > p; q--) begin
          entry_keys[q] = entry_keys[q-1];
          entry_coefs[q] = entry_coefs[q-1];
        end
        entry_keys[p] = op.idx;
        entry_coefs[p] = op.coef;
        entry_total++;
        r.status = ST_INSERTED;
        r.coef = op.coef;
      end
    end
    r.count = entry_total[CNT_W-1:0];
    expected_results.push_back(r);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      update_vector_and_predict(op_on_bus);
      kind_seen[op_on_bus.kind]++;
      ops_sent++;
      op_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || op_taken) begin
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= s_idle_pct) begin
        op_on_bus = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, op_on_bus.coef, op_on_bus.idx};
        s_axis_tuser <= op_on_bus.kind;
        s_axis_tlast <= op_on_bus.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    op_taken = 0;
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= r_idle_pct);
    end
  end

  always @(posedge clk) begin
    vec_resp_t got;
    vec_resp_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[2:0];
      got.count = m_axis_tdata[3 +: CNT_W];
      got.idx = m_axis_tdata[3 + CNT_W +: KEY_W];
      got.coef = m_axis_tdata[3 + CNT_W + KEY_W +: COEF_W];
      got.done = m_axis_tlast;
      resp_seen++;
      if (got.status < 6) status_seen[got.status]++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("ERROR: unexpected beat status=%0d count=%0d idx=%h coef=%h done=%b",
                   got.status, got.count, got.idx, got.coef, got.done);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.count !== want.count ||
            got.idx !== want.idx || got.coef !== want.coef || got.done !== want.done) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("ERROR: beat %0d exp status=%0d count=%0d idx=%h coef=%h done=%b",
                     resp_seen, want.status, want.count, want.idx, want.coef, want.done);
            $display("       got status=%0d count=%0d idx=%h coef=%h done=%b",
                     got.status, got.count, got.idx, got.coef, got.done);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("Timeout: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_store_zeros(input logic val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_STORE_ZEROS;
    pwdata <= {31'($urandom() >> 1), val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    keep_zeros = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_ops.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_op(input kind_t k, input logic [KEY_W-1:0] idx,
                          input logic [COEF_W-1:0] coef, input logic last);
    vec_op_t op;
    op.kind = k;
    op.idx = idx;
    op.coef = coef;
    op.last = last;
    pending_ops.push_back(op);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 50) return {{31{r[0]}}, 1'b0, $urandom()} ^ {{32{r[0]}}, 32'h0};
    if (r < 80) return {$urandom(), $urandom()};
    case ($urandom_range(0, 3))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return COEF_MAX - $urandom_range(0, 1000);
      default: return COEF_MIN + $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic vec_op_t pick_op();
    vec_op_t op;
    int r;
    r = $urandom_range(0, 99);
    op.kind = (r < 45) ? KIND_ACC : (r < 75) ? KIND_OVW : (r < 97) ? KIND_READ : KIND_CLEAR;
    op.coef = pick_coef();
    op.last = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (op.kind == KIND_READ) begin
      if (r < 80) op.idx = KEY_W'($urandom_range(0, 60));
      else if (r < 90) op.idx = KEY_W'($urandom() >> 1);
      else op.idx = KEY_W'($urandom_range(DEPTH - 1, DEPTH));
    end else begin
      if (r < 75) op.idx = KEY_W'($urandom_range(0, 47));
      else if (r < 90) op.idx = KEY_W'($urandom() >> 1);
      else op.idx = r[0] ? KEY_TOP : '0;
    end
    return op;
  endfunction

  initial begin
    int unsigned fill_keys [DEPTH];
    int unsigned tmp;
    int j;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    s_idle_pct = 27;
    r_idle_pct = 68;
    write_store_zeros(1'b1);
    queue_op(KIND_READ, 0, '0, 1'b0);
    queue_op(KIND_ACC, 5, '0, 1'b1);
    queue_op(KIND_ACC, KEY_TOP, COEF_MAX, 1'b0);
    queue_op(KIND_ACC, KEY_TOP, 64'd1, 1'b0);            // clamps high
    queue_op(KIND_ACC, 0, COEF_MIN, 1'b1);
    queue_op(KIND_ACC, 0, {COEF_W{1'b1}}, 1'b0);         // clamps low
    queue_op(KIND_OVW, 5, '0, 1'b0);
    queue_op(KIND_OVW, 3, 64'h0000_0001_8000_0000, 1'b0);
    queue_op(KIND_ACC, 3, 64'hFFFF_FFFD_8000_0000, 1'b1);
    queue_op(KIND_ACC, 4, {$urandom(), $urandom()}, 1'b0);
    for (int i = 0; i < 5; i++)
      queue_op(KIND_READ, KEY_W'(i), {$urandom(), $urandom()}, i[0]);
    queue_op(KIND_READ, 5, '0, 1'b0);
    queue_op(KIND_READ, KEY_TOP, COEF_MAX, 1'b1);
    queue_op(KIND_OVW, KEY_TOP, COEF_MIN, 1'b0);
    wait_idle();

    write_store_zeros(1'b0);
    queue_op(KIND_ACC, 3, '0, 1'b0);                     // dropped, entry exists
    queue_op(KIND_ACC, 6, '0, 1'b1);                     // dropped, no entry
    queue_op(KIND_OVW, 6, '0, 1'b0);                     // overwrite ignores store_zeros
    queue_op(KIND_ACC, 6, 64'd1, 1'b0);
    queue_op(KIND_CLEAR, KEY_TOP, COEF_MAX, 1'b1);
    queue_op(KIND_READ, 0, '0, 1'b0);
    wait_idle();

    // fill to capacity in shuffled order, receiver stalled for a long stretch
    write_store_zeros(1'b1);
    for (int i = 0; i < DEPTH; i++) fill_keys[i] = i * 5 + 2;
    for (int i = DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_keys[i];
      fill_keys[i] = fill_keys[j];
      fill_keys[j] = tmp;
    end
    long_hold_req = 1;
    for (int i = 0; i < DEPTH; i++)
      queue_op($urandom_range(0, 1) ? KIND_ACC : KIND_OVW, KEY_W'(fill_keys[i]), pick_coef(),
               (i % 32) == 31);
    queue_op(KIND_ACC, 0, {$urandom(), $urandom()}, 1'b0);  // full
    queue_op(KIND_OVW, KEY_TOP, '0, 1'b1);                  // full
    queue_op(KIND_ACC, 2, pick_coef(), 1'b0);
    queue_op(KIND_READ, KEY_W'(DEPTH - 1), '0, 1'b0);
    queue_op(KIND_READ, KEY_W'(DEPTH), '0, 1'b1);
    wait_idle();
    write_store_zeros(1'b0);
    queue_op(KIND_ACC, 1, '0, 1'b0);
    queue_op(KIND_ACC, 7, '0, 1'b0);
    queue_op(KIND_CLEAR, 0, '0, 1'b1);
    wait_idle();

    for (int c = 0; c < 4; c++) begin
      if (c == 0) begin
        s_idle_pct = 68;
        r_idle_pct = 27;
      end else if (c == 2) begin
        s_idle_pct = 0;
        r_idle_pct = 0;
      end
      write_store_zeros(c[0]);
      for (int i = 0; i < 100; i++) pending_ops.push_back(pick_op());
      wait_idle();
    end

    repeat (10) @(posedge clk);
    errors += expected_results.size();
    $display("Sent %0d beats (acc %0d, ovw %0d, clear %0d, read %0d), checked %0d results",
             ops_sent, kind_seen[KIND_ACC], kind_seen[KIND_OVW], kind_seen[KIND_CLEAR],
             kind_seen[KIND_READ], resp_seen);
    $display("Status counts: upd %0d ins %0d drop %0d full %0d rd_ok %0d rd_bad %0d",
             status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_DROPPED],
             status_seen[ST_FULL], status_seen[ST_READ_OK], status_seen[ST_READ_BAD]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
